>>> rtl/lsb_bit_extract_packer_defines.svh
// ----------------------------------------------------------------------------
// lsb bit extract packer assertion macros
// shared concurrent assertion forms for the packer rtl
// ----------------------------------------------------------------------------
`ifndef LSB_BIT_EXTRACT_PACKER_DEFINES_SVH
`define LSB_BIT_EXTRACT_PACKER_DEFINES_SVH

// same-cycle implication, checked out of reset
`define LBEP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lbep assertion failed");

// next-cycle implication, checked out of reset
`define LBEP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lbep assertion failed");

`endif

>>> rtl/lbep_pkg.sv
// ----------------------------------------------------------------------------
// lbep_pkg
// shared widths, codes and register indexes of the lsb bit extract packer
// ----------------------------------------------------------------------------
`default_nettype none

package lbep_pkg;

    localparam int MAX_SLOTS   = 4;
    localparam int CHAN_W      = 8;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 4;

    typedef logic [CHAN_W-1:0] chan_t;

    typedef enum logic [1:0] {
        CHAN_RED   = 2'd0,
        CHAN_GREEN = 2'd1,
        CHAN_BLUE  = 2'd2,
        CHAN_ALPHA = 2'd3
    } chan_sel_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CHANNEL_COUNT    = 3'd0,
        REG_SLOT0_CHANNEL    = 3'd1,
        REG_SLOT1_CHANNEL    = 3'd2,
        REG_SLOT2_CHANNEL    = 3'd3,
        REG_SLOT3_CHANNEL    = 3'd4,
        REG_BITS_PER_CHANNEL = 3'd5,
        REG_ALPHA_PRESENT    = 3'd6
    } cfg_reg_t;

endpackage

`default_nettype wire

>>> rtl/lsb_bit_extract_packer.sv
// ----------------------------------------------------------------------------
// lsb_bit_extract_packer
// packs the low bits of selected rgba channels into bytes, msb first
// ----------------------------------------------------------------------------
//  channel | handshake                 | payload
//  --------+---------------------------+------------------------------------
//  pixel   | pixel_valid / pixel_ready | red, green, blue, alpha
//  byte    | byte_valid / byte_ready   | hidden_byte, last_of_pixel
//  config  | cfg_we                    | cfg_index, cfg_data
//
//  one pixel is taken per cycle into the input stage while the result stage
//  frees in time, packed in one pass into a result stage of up to four bytes,
//  which drains one byte per cycle while byte_ready is high, held by a pixel
//  until its last byte is taken; one that completes no byte shows nothing
//  reset clears the accumulator, both stages and the registers to defaults
//  a stalled byte beat holds the result stage; one more pixel waits in front
// ----------------------------------------------------------------------------
`default_nettype none

module lsb_bit_extract_packer
(
    input  wire                                 clk,
    input  wire                                 rst_n,
    input  wire                                 cfg_we,
    input  wire  [lbep_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire  [lbep_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  wire                                 pixel_valid,
    output logic                                pixel_ready,
    input  wire  lbep_pkg::chan_t               red,
    input  wire  lbep_pkg::chan_t               green,
    input  wire  lbep_pkg::chan_t               blue,
    input  wire  lbep_pkg::chan_t               alpha,
    output logic                                byte_valid,
    input  wire                                 byte_ready,
    output logic [7:0]                          hidden_byte,
    output logic                                last_of_pixel
);

    import lbep_pkg::*;

`include "lsb_bit_extract_packer_defines.svh"

    // configuration
    logic [2:0]  channel_count_reg;
    logic [1:0]  slot_sel_reg [MAX_SLOTS];
    logic [3:0]  bits_per_channel_reg;
    logic        alpha_present_reg;

    // input stage
    logic        in_valid_reg;
    chan_t       red_reg, green_reg, blue_reg, alpha_reg;

    // packing state
    logic [7:0]  acc_reg;
    logic [2:0]  fill_reg;

    // result stage
    logic        res_valid_reg;
    logic [7:0]  byte_reg [MAX_SLOTS];
    logic [2:0]  cnt_reg;
    logic [1:0]  idx_reg;

    logic        out_fire, res_last, res_free, move;
    logic [2:0]  slot_lim;
    logic [3:0]  take_bits;
    logic [7:0]  take_mask;
    logic [31:0] stream;
    logic [5:0]  stream_len;
    logic [31:0] stream_left;
    logic [39:0] combined;
    logic [5:0]  total;
    logic [2:0]  byte_cnt;
    logic [7:0]  acc_next;

    function automatic chan_t chan_pick(input logic [1:0] sel, input chan_t r,
                                        input chan_t g, input chan_t b, input chan_t a);
        chan_t val;
        case (sel)
            CHAN_RED:   val = r;
            CHAN_GREEN: val = g;
            CHAN_BLUE:  val = b;
            default:    val = a;
        endcase
        return val;
    endfunction

    // config writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            channel_count_reg    <= 3'd3;
            slot_sel_reg[0]      <= CHAN_RED;
            slot_sel_reg[1]      <= CHAN_GREEN;
            slot_sel_reg[2]      <= CHAN_BLUE;
            slot_sel_reg[3]      <= CHAN_ALPHA;
            bits_per_channel_reg <= 4'd1;
            alpha_present_reg    <= 1'b1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_CHANNEL_COUNT:    channel_count_reg    <= cfg_data[2:0];
                REG_SLOT0_CHANNEL:    slot_sel_reg[0]      <= cfg_data[1:0];
                REG_SLOT1_CHANNEL:    slot_sel_reg[1]      <= cfg_data[1:0];
                REG_SLOT2_CHANNEL:    slot_sel_reg[2]      <= cfg_data[1:0];
                REG_SLOT3_CHANNEL:    slot_sel_reg[3]      <= cfg_data[1:0];
                REG_BITS_PER_CHANNEL: bits_per_channel_reg <= cfg_data;
                REG_ALPHA_PRESENT:    alpha_present_reg    <= cfg_data[0];
                default:              ;
            endcase
        end
    end

    // handshake
    assign out_fire    = res_valid_reg && byte_ready;
    assign res_last    = ({1'b0, idx_reg} + 3'd1) == cnt_reg;
    assign res_free    = !res_valid_reg || (out_fire && res_last);
    assign move        = in_valid_reg && res_free;
    assign pixel_ready = !in_valid_reg || move;

    assign byte_valid    = res_valid_reg;
    assign hidden_byte   = byte_reg[idx_reg];
    assign last_of_pixel = res_last;

    // gather the pixel's bits, right-justified
    assign slot_lim  = (channel_count_reg > 3'(MAX_SLOTS)) ? 3'(MAX_SLOTS) : channel_count_reg;
    assign take_bits = (bits_per_channel_reg > 4'd8) ? 4'd8 : bits_per_channel_reg;
    assign take_mask = 8'((9'd1 << take_bits) - 9'd1);

    always_comb
    begin
        logic [1:0] sel;
        logic       use_slot;
        stream     = '0;
        stream_len = '0;
        for (int s = 0; s < MAX_SLOTS; s++)
        begin
            sel      = slot_sel_reg[s];
            use_slot = (3'(s) < slot_lim) && !((sel == CHAN_ALPHA) && !alpha_present_reg);
            if (use_slot)
            begin
                stream     = (stream << take_bits) |
                             {24'b0, chan_pick(sel, red_reg, green_reg, blue_reg, alpha_reg)
                                     & take_mask};
                stream_len = stream_len + 6'(take_bits);
            end
        end
    end

    // merge behind the partial byte
    assign stream_left = stream << (6'd32 - stream_len);
    assign combined    = {acc_reg, 32'b0} | ({stream_left, 8'b0} >> fill_reg);
    assign total       = {3'b0, fill_reg} + stream_len;
    assign byte_cnt    = total[5:3];

    always_comb
    begin
        case (byte_cnt)
            3'd0:    acc_next = combined[39:32];
            3'd1:    acc_next = combined[31:24];
            3'd2:    acc_next = combined[23:16];
            3'd3:    acc_next = combined[15:8];
            default: acc_next = combined[7:0];
        endcase
    end

    // input stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (pixel_ready)
        begin
            in_valid_reg <= pixel_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pixel_valid && pixel_ready)
        begin
            red_reg   <= red;
            green_reg <= green;
            blue_reg  <= blue;
            alpha_reg <= alpha;
        end
    end

    // packing state and result stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg       <= '0;
            fill_reg      <= '0;
            res_valid_reg <= 1'b0;
            cnt_reg       <= '0;
            idx_reg       <= '0;
        end
        else if (move)
        begin
            acc_reg       <= acc_next;
            fill_reg      <= total[2:0];
            res_valid_reg <= byte_cnt != 3'd0;
            cnt_reg       <= byte_cnt;
            idx_reg       <= '0;
        end
        else if (out_fire)
        begin
            idx_reg <= idx_reg + 2'd1;
            if (res_last)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (move)
        begin
            byte_reg[0] <= combined[39:32];
            byte_reg[1] <= combined[31:24];
            byte_reg[2] <= combined[23:16];
            byte_reg[3] <= combined[15:8];
        end
    end

    // checks
    `LBEP_ASSERT_NOW(a_idx_in_range, clk, rst_n, res_valid_reg, {1'b0, idx_reg} < cnt_reg)
    `LBEP_ASSERT_NOW(a_acc_tail_clear, clk, rst_n, 1'b1, (acc_reg & (8'hff >> fill_reg)) == 8'd0)
    `LBEP_ASSERT_NEXT(a_drain_ends, clk, rst_n,
                      out_fire && res_last && !in_valid_reg, !res_valid_reg)
    `LBEP_ASSERT_NEXT(a_idx_steps, clk, rst_n,
                      out_fire && !res_last, res_valid_reg && idx_reg == $past(idx_reg) + 2'd1)

endmodule

`default_nettype wire
